/* rtl/wdsmp_pkg.sv */
// Shared constants, codes and the cell command type of the weighted discrete sampler.
`default_nettype none

package wdsmp_pkg;

  localparam int unsigned KEY_W           = 32;
  localparam int unsigned UNI_W           = 32;
  localparam int unsigned IN_WEIGHT_W     = 16;
  localparam int unsigned TYPE_W          = 2;
  localparam int unsigned STAT_W          = 2;
  localparam int unsigned DEF_TABLE_DEPTH = 64;
  localparam int unsigned DEF_WEIGHT_BITS = 16;

  typedef enum logic [TYPE_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic             ins_en;
    logic             rep_en;
    logic [KEY_W-1:0] key;
  } cell_cmd_t;

endpackage

`default_nettype wire

/* rtl/weighted_discrete_sampler.sv */
// Top level of the weighted discrete sampler: request capture, control and the cell row.
//
// Usage: an item is taken at a rising edge with start_i high and busy_o low;
// req_type_i selects insert (key_value_i, weight_i), sample (uniform_i) or clear.
// Every transaction yields one result: sample_value_o, status_o and entry_count_o
// are valid for exactly one cycle while done_o is high, and the receiver cannot
// hold them off. busy_o is low again in that cycle, so the next item may be
// started while the result is shown.
// A sample makes two passes down the cell row, one for the running sums and one
// for the selection, each moving one cell per cycle, with the shift-and-add
// threshold unit between them. When the total weight is zero it ends after the
// first pass with status empty.
// Items are taken one at a time. Reset empties the table at once by clearing
// the entry count; cell contents are not cleared and are never read before
// they are written.
`default_nettype none

module weighted_discrete_sampler
  import wdsmp_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic [TYPE_W-1:0]                     req_type_i,
  input  logic signed [KEY_W-1:0]               key_value_i,
  input  logic [IN_WEIGHT_W-1:0]                weight_i,
  input  logic [UNI_W-1:0]                      uniform_i,
  output logic                                  done_o,
  output logic signed [KEY_W-1:0]               sample_value_o,
  output logic [STAT_W-1:0]                     status_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]      entry_count_o
);

  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned WAVE_W = $clog2(TABLE_DEPTH);
  localparam int unsigned SUM_W  = WEIGHT_BITS + $clog2(TABLE_DEPTH);
  localparam int unsigned MAXW_W = (WEIGHT_BITS > IN_WEIGHT_W) ? WEIGHT_BITS : IN_WEIGHT_W;
  localparam logic [WAVE_W-1:0] WAVE_LAST = WAVE_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(TABLE_DEPTH);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_INS  = 7'b0000010,
    S_SUM  = 7'b0000100,
    S_CHK  = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_SEL  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [WAVE_W-1:0]   wave_q, wave_d;
  logic                done_q, done_d;
  logic [KEY_W-1:0]    value_q, value_d;
  status_e             status_q, status_d;
  logic [KEY_W-1:0]    key_q;
  logic [WEIGHT_BITS-1:0] wgt_q;
  logic [UNI_W-1:0]    u_q;
  logic                accept;
  logic [MAXW_W-1:0]   wgt_wide;
  logic                mul_start, mul_done;
  logic [SUM_W-1:0]    need;

  logic [TABLE_DEPTH:0]                  lt_ch;
  logic [TABLE_DEPTH:0][KEY_W-1:0]       key_ch;
  logic [TABLE_DEPTH:0][WEIGHT_BITS-1:0] wgt_ch;
  logic [TABLE_DEPTH:0][SUM_W-1:0]       run_ch;
  logic [TABLE_DEPTH:0]                  found_ch;
  logic [TABLE_DEPTH:0][KEY_W-1:0]       sel_ch;
  logic [TABLE_DEPTH-1:0]                eq_v;
  logic                                  any_eq, full;
  cell_cmd_t                             cmd;

  assign accept   = start_i && (state_q == S_IDLE);
  assign wgt_wide = MAXW_W'(weight_i);
  assign any_eq   = |eq_v;
  assign full     = (count_q == FULL_CNT);

  assign cmd.ins_en = (state_q == S_INS) && !any_eq && !full;
  assign cmd.rep_en = (state_q == S_INS) && any_eq;
  assign cmd.key    = key_q;

  // The head of the row sees an empty predecessor that orders below every key.
  assign lt_ch[0]    = 1'b1;
  assign key_ch[0]   = '0;
  assign wgt_ch[0]   = '0;
  assign run_ch[0]   = '0;
  assign found_ch[0] = 1'b0;
  assign sel_ch[0]   = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(g);

    wdsmp_cell #(
      .WB    (WEIGHT_BITS),
      .SUM_W (SUM_W)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .wgt_i        (wgt_q),
      .valid_i      (IDX < count_q),
      .room_i       (IDX <= count_q),
      .left_lt_i    (lt_ch[g]),
      .left_key_i   (key_ch[g]),
      .left_wgt_i   (wgt_ch[g]),
      .left_run_i   (run_ch[g]),
      .left_found_i (found_ch[g]),
      .left_sel_i   (sel_ch[g]),
      .need_i       (need),
      .lt_o         (lt_ch[g+1]),
      .eq_o         (eq_v[g]),
      .key_o        (key_ch[g+1]),
      .wgt_o        (wgt_ch[g+1]),
      .run_o        (run_ch[g+1]),
      .found_o      (found_ch[g+1]),
      .sel_o        (sel_ch[g+1])
    );
  end

  wdsmp_mul #(
    .SUM_W (SUM_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .u_i     (u_q),
    .total_i (run_ch[TABLE_DEPTH]),
    .done_o  (mul_done),
    .need_o  (need)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    wave_d    = wave_q;
    done_d    = 1'b0;
    value_d   = value_q;
    status_d  = status_q;
    mul_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          wave_d = '0;
          unique case (req_type_i)
            REQ_INSERT: state_d = S_INS;
            REQ_SAMPLE: state_d = S_SUM;
            REQ_CLEAR: begin
              count_d  = '0;
              done_d   = 1'b1;
              value_d  = '0;
              status_d = ST_OK;
            end
            default: begin
              done_d   = 1'b1;
              value_d  = '0;
              status_d = ST_OK;
            end
          endcase
        end
      end
      S_INS: begin
        done_d   = 1'b1;
        value_d  = '0;
        status_d = ST_OK;
        if (!any_eq) begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
        state_d = S_IDLE;
      end
      S_SUM: begin
        // Running sums settle one cell further on each cycle.
        wave_d = wave_q + 1'b1;
        if (wave_q == WAVE_LAST) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (run_ch[TABLE_DEPTH] == '0) begin
          done_d   = 1'b1;
          value_d  = '0;
          status_d = ST_EMPTY;
          state_d  = S_IDLE;
        end else begin
          mul_start = 1'b1;
          state_d   = S_MUL;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          wave_d  = '0;
          state_d = S_SEL;
        end
      end
      S_SEL: begin
        wave_d = wave_q + 1'b1;
        if (wave_q == WAVE_LAST) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        done_d   = 1'b1;
        value_d  = sel_ch[TABLE_DEPTH];
        status_d = ST_OK;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      wave_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      wave_q  <= wave_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    status_q <= status_d;
    if (accept) begin
      key_q <= key_value_i;
      wgt_q <= wgt_wide[WEIGHT_BITS-1:0];
      u_q   <= uniform_i;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign sample_value_o = value_q;
  assign status_o       = status_q;
  assign entry_count_o  = count_q;

endmodule

`default_nettype wire

/* rtl/wdsmp_cell.sv */
// One cell of the sorted table: holds a pair, its running sum and the draw selection stage.
`default_nettype none

module wdsmp_cell
  import wdsmp_pkg::*;
#(
  parameter int unsigned WB    = DEF_WEIGHT_BITS,
  parameter int unsigned SUM_W = DEF_WEIGHT_BITS + $clog2(DEF_TABLE_DEPTH)
) (
  input  logic             clk_i,
  input  cell_cmd_t        cmd_i,
  input  logic [WB-1:0]    wgt_i,
  input  logic             valid_i,
  input  logic             room_i,
  input  logic             left_lt_i,
  input  logic [KEY_W-1:0] left_key_i,
  input  logic [WB-1:0]    left_wgt_i,
  input  logic [SUM_W-1:0] left_run_i,
  input  logic             left_found_i,
  input  logic [KEY_W-1:0] left_sel_i,
  input  logic [SUM_W-1:0] need_i,
  output logic             lt_o,
  output logic             eq_o,
  output logic [KEY_W-1:0] key_o,
  output logic [WB-1:0]    wgt_o,
  output logic [SUM_W-1:0] run_o,
  output logic             found_o,
  output logic [KEY_W-1:0] sel_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic [WB-1:0]    wgt_q, wgt_d;
  logic [SUM_W-1:0] run_q, run_d;
  logic             found_q, found_d;
  logic [KEY_W-1:0] sel_q, sel_d;
  logic             hit;

  // Flipping the sign bit turns the signed order into an unsigned one.
  assign lt_o = valid_i &&
                ({~key_q[KEY_W-1], key_q[KEY_W-2:0]} <
                 {~cmd_i.key[KEY_W-1], cmd_i.key[KEY_W-2:0]});
  assign eq_o = valid_i && (key_q == cmd_i.key);

  always_comb begin
    key_d = key_q;
    wgt_d = wgt_q;
    if (cmd_i.rep_en && eq_o) begin
      wgt_d = wgt_i;
    end
    // Cells at or above the insertion point move up by one place.
    if (cmd_i.ins_en && room_i && !lt_o) begin
      if (left_lt_i) begin
        key_d = cmd_i.key;
        wgt_d = wgt_i;
      end else begin
        key_d = left_key_i;
        wgt_d = left_wgt_i;
      end
    end
  end

  assign run_d   = left_run_i + (valid_i ? SUM_W'(wgt_q) : '0);
  assign hit     = valid_i && (wgt_q != '0) && (run_q >= need_i);
  assign found_d = left_found_i || hit;
  assign sel_d   = left_found_i ? left_sel_i : key_q;

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    wgt_q   <= wgt_d;
    run_q   <= run_d;
    found_q <= found_d;
    sel_q   <= sel_d;
  end

  assign key_o   = key_q;
  assign wgt_o   = wgt_q;
  assign run_o   = run_q;
  assign found_o = found_q;
  assign sel_o   = sel_q;

endmodule

`default_nettype wire

/* rtl/wdsmp_mul.sv */
// Shift-and-add unit that forms the threshold ceil(u * total / 2^32).
`default_nettype none

module wdsmp_mul
  import wdsmp_pkg::*;
#(
  parameter int unsigned SUM_W = DEF_WEIGHT_BITS + $clog2(DEF_TABLE_DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [UNI_W-1:0] u_i,
  input  logic [SUM_W-1:0] total_i,
  output logic             done_o,
  output logic [SUM_W-1:0] need_o
);

  localparam int unsigned ACC_W = SUM_W + UNI_W;
  localparam int unsigned CNT_W = $clog2(UNI_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(UNI_W - 1);

  logic             run_q, fin_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [ACC_W-1:0] acc_q;
  logic [UNI_W-1:0] u_q;
  logic [SUM_W-1:0] tot_q;
  logic [SUM_W-1:0] need_q;
  logic [SUM_W:0]   part;
  logic [SUM_W:0]   rounded;

  // One multiplier bit per cycle, least significant first.
  assign part    = {1'b0, acc_q[ACC_W-1:UNI_W]} + (u_q[0] ? {1'b0, tot_q} : '0);
  assign rounded = {1'b0, acc_q[ACC_W-1:UNI_W]} +
                   (SUM_W+1)'(acc_q[UNI_W-1:0] != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      u_q   <= u_i;
      tot_q <= total_i;
    end else if (run_q) begin
      acc_q <= {part, acc_q[UNI_W-1:1]};
      u_q   <= u_q >> 1;
    end
    if (fin_q) begin
      need_q <= rounded[SUM_W-1:0];
    end
  end

  assign done_o = done_q;
  assign need_o = need_q;

endmodule

`default_nettype wire
